// File: sv/wsfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wsfd_pkg;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam logic [31:0] MAX_MSG_RESET = 32'd1048576;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [2:0] KIND_MSG   = 3'd0;
    localparam logic [2:0] KIND_PING  = 3'd1;
    localparam logic [2:0] KIND_PONG  = 3'd2;
    localparam logic [2:0] KIND_CLOSE = 3'd3;
    localparam logic [2:0] KIND_ERR   = 3'd4;

    localparam logic [3:0] OP_CONT  = 4'd0;
    localparam logic [3:0] OP_TEXT  = 4'd1;
    localparam logic [3:0] OP_BIN   = 4'd2;
    localparam logic [3:0] OP_CLOSE = 4'd8;
    localparam logic [3:0] OP_PING  = 4'd9;
    localparam logic [3:0] OP_PONG  = 4'd10;

    localparam logic [3:0] ERR_NONE   = 4'd0;
    localparam logic [3:0] ERR_RSV    = 4'd1;
    localparam logic [3:0] ERR_MSB    = 4'd2;
    localparam logic [3:0] ERR_FRAGC  = 4'd3;
    localparam logic [3:0] ERR_CTLLEN = 4'd4;
    localparam logic [3:0] ERR_BIG    = 4'd5;
    localparam logic [3:0] ERR_ORPHAN = 4'd6;
    localparam logic [3:0] ERR_MIDFR  = 4'd7;
    localparam logic [3:0] ERR_OPCODE = 4'd8;
    localparam logic [3:0] ERR_REASM  = 4'd9;

    localparam logic [15:0] CLOSE_DEFAULT = 16'd1000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic        has_data;
        logic        last;
        logic        binary;
        logic [15:0] close_code;
        logic [3:0]  error_code;
    } t_result;
endpackage
`default_nettype wire

// File: sv/wsfd_parser.sv
`timescale 1ns / 1ps
`default_nettype none
module wsfd_parser #(
    parameter int COUNT_WIDTH = wsfd_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_take,
    input  wire logic [7:0]        i_byte,
    input  wire logic [31:0]       i_max_msg,
    output wsfd_pkg::t_result      o_res,
    output logic                   o_res_valid
);
    typedef enum logic [2:0] {
        PH_HDR0, PH_HDR1, PH_EXTLEN, PH_MASK, PH_PAYLOAD, PH_ERROR
    } t_phase;

    localparam logic [63:0] CAP = (64'd1 << COUNT_WIDTH) - 64'd1;

    t_phase                 r_phase;
    logic                   r_fin, r_mask_on, r_frag, r_frag_bin;
    logic [3:0]             r_op, r_left;
    logic [63:0]            r_len;
    logic [COUNT_WIDTH-1:0] r_idx;
    logic [2:0]             r_rsv;
    logic [31:0]            r_key;
    logic [COUNT_WIDTH:0]   r_total;
    logic [15:0]            r_close;

    logic [63:0]          lim;
    logic                 ctrl, lof, ext_done, mask_done, go_end, bin_cur;
    logic [63:0]          len_new;
    logic [3:0]           err;
    logic [COUNT_WIDTH:0] base;
    logic [64:0]          sum;
    logic [7:0]           d;
    logic [4:0]           sh;

    always_comb begin
        lim = ({32'd0, i_max_msg} < CAP) ? {32'd0, i_max_msg} : CAP;
    end

    assign ctrl = r_op[3];
    assign bin_cur = (r_op == wsfd_pkg::OP_CONT) ? r_frag_bin : (r_op == wsfd_pkg::OP_BIN);
    assign ext_done = (r_left == 4'd1);
    assign mask_done = (r_left == 4'd1);
    assign len_new = (r_phase == PH_HDR1) ? {57'd0, i_byte[6:0]}
                   : (r_phase == PH_EXTLEN) ? {r_len[55:0], i_byte} : r_len;
    assign base = r_frag ? r_total : '0;
    assign sum = 65'(base) + {1'b0, len_new};

    always_comb begin
        go_end = 1'b0;
        unique case (r_phase)
            PH_HDR1:   go_end = (i_byte[6:0] < 7'd126) && !i_byte[7];
            PH_EXTLEN: go_end = ext_done && !r_mask_on;
            PH_MASK:   go_end = mask_done;
            default:   go_end = 1'b0;
        endcase
    end

    always_comb begin
        err = wsfd_pkg::ERR_NONE;
        if (r_rsv != 3'd0) err = wsfd_pkg::ERR_RSV;
        else if (len_new[63]) err = wsfd_pkg::ERR_MSB;
        else if (ctrl && !r_fin) err = wsfd_pkg::ERR_FRAGC;
        else if (ctrl && len_new > 64'd125) err = wsfd_pkg::ERR_CTLLEN;
        else if (!ctrl && len_new > lim) err = wsfd_pkg::ERR_BIG;
        else if (r_op == wsfd_pkg::OP_CONT && !r_frag) err = wsfd_pkg::ERR_ORPHAN;
        else if ((r_op == wsfd_pkg::OP_TEXT || r_op == wsfd_pkg::OP_BIN) && r_frag)
            err = wsfd_pkg::ERR_MIDFR;
        else if (!(r_op <= wsfd_pkg::OP_BIN ||
                   (r_op >= wsfd_pkg::OP_CLOSE && r_op <= wsfd_pkg::OP_PONG)))
            err = wsfd_pkg::ERR_OPCODE;
        else if (!ctrl && (r_frag || !r_fin) && sum > {1'b0, lim})
            err = wsfd_pkg::ERR_REASM;
    end

    assign lof = ({{(64-COUNT_WIDTH){1'b0}}, r_idx} + 64'd1) >= r_len;
    assign sh = 5'd24 - {r_idx[1:0], 3'b000};
    assign d = r_mask_on ? (i_byte ^ 8'(r_key >> sh)) : i_byte;

    always_ff @(posedge i_clk) begin
        o_res_valid <= 1'b0;
        if (!i_rst_n) begin
            r_phase <= PH_HDR0;
            r_fin <= 1'b0; r_op <= '0; r_mask_on <= 1'b0; r_left <= '0;
            r_len <= '0; r_idx <= '0; r_rsv <= '0; r_key <= '0;
            r_frag <= 1'b0; r_frag_bin <= 1'b0; r_total <= '0; r_close <= '0;
        end else if (i_take) begin
            unique case (r_phase)
                PH_ERROR: ;
                PH_HDR1: begin
                    r_mask_on <= i_byte[7];
                    r_len <= (i_byte[6:0] >= 7'd126) ? 64'd0 : len_new;
                    if (i_byte[6:0] >= 7'd126) begin
                        r_left <= (i_byte[6:0] == 7'd126) ? 4'd2 : 4'd8;
                        r_phase <= PH_EXTLEN;
                    end else if (i_byte[7]) begin
                        r_left <= 4'd4;
                        r_phase <= PH_MASK;
                    end
                end
                PH_EXTLEN: begin
                    r_len <= len_new;
                    r_left <= r_left - 4'd1;
                    if (ext_done && r_mask_on) begin
                        r_left <= 4'd4;
                        r_phase <= PH_MASK;
                    end
                end
                PH_MASK: begin
                    r_key <= {r_key[23:0], i_byte};
                    r_left <= r_left - 4'd1;
                end
                PH_PAYLOAD: begin
                    r_idx <= r_idx + 1'b1;
                    o_res.data_byte <= d;
                    o_res.has_data <= 1'b1;
                    o_res.binary <= 1'b0;
                    o_res.close_code <= '0;
                    o_res.error_code <= wsfd_pkg::ERR_NONE;
                    o_res.last <= lof;
                    o_res_valid <= 1'b1;
                    if (r_op == wsfd_pkg::OP_CLOSE) begin
                        o_res.kind <= wsfd_pkg::KIND_CLOSE;
                        o_res.close_code <= r_close;
                        if (r_idx < COUNT_WIDTH'(2)) begin
                            o_res.has_data <= 1'b0;
                            o_res.data_byte <= '0;
                            o_res_valid <= lof;
                            if (!lof) begin
                                if (r_idx == '0) r_close <= {d, 8'd0};
                                else r_close <= {r_close[15:8], d};
                            end else if (r_idx == COUNT_WIDTH'(1)) begin
                                r_close <= {r_close[15:8], d};
                                o_res.close_code <= {r_close[15:8], d};
                            end
                        end
                    end else if (r_op == wsfd_pkg::OP_PING) begin
                        o_res.kind <= wsfd_pkg::KIND_PING;
                    end else if (r_op == wsfd_pkg::OP_PONG) begin
                        o_res.kind <= wsfd_pkg::KIND_PONG;
                    end else begin
                        o_res.kind <= wsfd_pkg::KIND_MSG;
                        o_res.last <= lof && r_fin;
                        o_res.binary <= bin_cur;
                    end
                    if (lof) begin
                        r_phase <= PH_HDR0;
                        if (!ctrl && r_fin) begin
                            r_frag <= 1'b0;
                            r_total <= '0;
                        end
                    end
                end
                default: begin
                    r_fin <= i_byte[7];
                    r_op <= i_byte[3:0];
                    r_rsv <= i_byte[6:4];
                    r_key <= '0;
                    r_phase <= PH_HDR1;
                end
            endcase

            if (go_end) begin
                r_rsv <= '0;
                r_idx <= '0;
                o_res.data_byte <= '0;
                o_res.has_data <= 1'b0;
                o_res.last <= 1'b1;
                o_res.binary <= 1'b0;
                o_res.close_code <= '0;
                o_res.error_code <= err;
                if (err != wsfd_pkg::ERR_NONE) begin
                    r_phase <= PH_ERROR;
                    o_res.kind <= wsfd_pkg::KIND_ERR;
                    o_res_valid <= 1'b1;
                end else begin
                    if (!ctrl) begin
                        if (!r_frag && !r_fin) begin
                            r_frag <= 1'b1;
                            r_frag_bin <= (r_op == wsfd_pkg::OP_BIN);
                            r_total <= (COUNT_WIDTH+1)'(len_new);
                        end else if (r_frag) begin
                            r_total <= (COUNT_WIDTH+1)'(sum);
                        end
                    end
                    r_close <= wsfd_pkg::CLOSE_DEFAULT;
                    if (len_new != 64'd0) begin
                        r_phase <= PH_PAYLOAD;
                    end else begin
                        r_phase <= PH_HDR0;
                        if (!ctrl && r_fin) begin
                            r_frag <= 1'b0;
                            r_total <= '0;
                        end
                        if (ctrl) begin
                            o_res.kind <= (r_op == wsfd_pkg::OP_PING) ? wsfd_pkg::KIND_PING
                                        : (r_op == wsfd_pkg::OP_PONG) ? wsfd_pkg::KIND_PONG
                                        : (r_op == wsfd_pkg::OP_CLOSE) ? wsfd_pkg::KIND_CLOSE
                                        : wsfd_pkg::KIND_MSG;
                            o_res.close_code <= (r_op == wsfd_pkg::OP_CLOSE)
                                              ? wsfd_pkg::CLOSE_DEFAULT : 16'd0;
                            o_res_valid <= 1'b1;
                        end else if (r_fin) begin
                            o_res.kind <= wsfd_pkg::KIND_MSG;
                            o_res.binary <= bin_cur;
                            o_res_valid <= 1'b1;
                        end
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// File: sv/wsfd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module wsfd_queue (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire wsfd_pkg::t_result i_res,
    input  wire logic         i_pop,
    output wsfd_pkg::t_result o_res,
    output logic              o_valid,
    output logic              o_room
);
    localparam int AW = $clog2(wsfd_pkg::QUEUE_DEPTH);
    wsfd_pkg::t_result r_mem [wsfd_pkg::QUEUE_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_res = r_mem[r_rp];
    assign o_room = (r_cnt < (AW+1)'(wsfd_pkg::QUEUE_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end
endmodule
`default_nettype wire

// File: sv/websocket_frame_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// websocket frame decoder: one received byte per cycle in, at most one result per byte out.
// the parser accepts a byte every cycle while the four-entry result queue has room for
// the result in flight; results leave one per cycle while i_stall is low, so output stalls
// only hold the input once two results wait; each is registered in the parser, then queued.
module websocket_frame_decoder #(
    parameter int COUNT_WIDTH = wsfd_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_kind,
    output logic [7:0]       o_data_byte,
    output logic             o_has_data,
    output logic             o_last,
    output logic             o_binary,
    output logic [15:0]      o_close_code,
    output logic [3:0]       o_error_code
);
    logic [31:0]       r_max_msg;
    logic              take, res_valid, room, pop;
    wsfd_pkg::t_result res, q_res;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_max_msg <= wsfd_pkg::MAX_MSG_RESET;
        else if (i_cfg_valid) r_max_msg <= i_cfg_data;
    end

    assign o_stall = !room;
    assign take = i_valid && room;
    assign pop = o_valid && !i_stall;

    wsfd_parser #(.COUNT_WIDTH(COUNT_WIDTH)) u_parser (
        .i_clk, .i_rst_n, .i_take(take), .i_byte(i_rx_byte), .i_max_msg(r_max_msg),
        .o_res(res), .o_res_valid(res_valid)
    );

    wsfd_queue u_queue (
        .i_clk, .i_rst_n, .i_push(res_valid), .i_res(res), .i_pop(pop),
        .o_res(q_res), .o_valid(o_valid), .o_room(room)
    );

    assign o_kind = q_res.kind;
    assign o_data_byte = q_res.data_byte;
    assign o_has_data = q_res.has_data;
    assign o_last = q_res.last;
    assign o_binary = q_res.binary;
    assign o_close_code = q_res.close_code;
    assign o_error_code = q_res.error_code;
endmodule
`default_nettype wire

// File: sv/wsfd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module wsfd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [2:0]  o_kind,
    input wire logic        o_has_data,
    input wire logic        o_last,
    input wire logic        o_binary,
    input wire logic [15:0] o_close_code,
    input wire logic [3:0]  o_error_code
);
    a_err_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_error_code != wsfd_pkg::ERR_NONE) == (o_kind == wsfd_pkg::KIND_ERR)))
        else $error("error code without error kind");
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == wsfd_pkg::KIND_ERR) |-> (o_last && !o_has_data))
        else $error("error result malformed");
    a_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind != wsfd_pkg::KIND_MSG) |-> !o_binary)
        else $error("binary on non message");
    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_kind == wsfd_pkg::KIND_ERR) |=> !o_valid)
        else $error("result after error");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_close_code)))
        else $error("stalled result changed");
endmodule

bind websocket_frame_decoder wsfd_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_stall, .o_kind, .o_has_data, .o_last,
    .o_binary, .o_close_code, .o_error_code
);
`default_nettype wire
